### src/modulation_matrix_accumulator_assert.svh
// assertion macros for the modulation matrix
`ifndef MODULATION_MATRIX_ACCUMULATOR_ASSERT_SVH
`define MODULATION_MATRIX_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMA_ASSERT(label, clk, rst_n, prop, msg)
`define MMA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// types and constants shared by the modulation matrix modules
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int NUM_SRC = 9;
  localparam int SRC_W   = 4;
  localparam int DEST_W  = 4;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 32;

  typedef enum logic [2:0] {
    REQ_SET_SRC = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_PROCESS = 3'd4
  } req_e;

  localparam logic [SRC_W-1:0] SRC_VELOCITY = 4'd4;
  localparam logic [SRC_W-1:0] SRC_NOTE     = 4'd5;
  localparam logic [SRC_W-1:0] SRC_CC       = 4'd6;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [SRC_W-1:0]  source_sel;
    logic [DEST_W-1:0] dest_sel;
    logic signed [15:0] source_value;
    logic signed [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [DEST_W-1:0]       dest_index;
    logic signed [ACC_W-1:0] dest_value;
    logic                    status;
    logic                    last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_ACK,
    ST_ZERO,
    ST_CONV,
    ST_MAC,
    ST_MUL,
    ST_ADD,
    ST_EMIT,
    ST_WAIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic scan_clr;   // reset scan and hit/free trackers
    logic scan_step;  // look at one connection
    logic do_update;  // commit add/clear/set
    logic zero_acc;   // clear one accumulator
    logic conv_step;  // one step of the source conversion
    logic mac_read;   // read a connection
    logic mul;        // multiply
    logic add;        // accumulate
    logic emit_load;  // load one output item
    logic ack_load;   // load an acknowledgement
    logic idx_clr;    // reset walk index
    logic idx_inc;    // advance walk index
  } mma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;   // walk index on its final entry
    logic conv_done;  // conversion finished
    logic mac_skip;   // current connection not used
    logic emit_last;  // final destination to emit
  } mma_sts_t;

endpackage

### src/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// request sequencer: scan, update, ack, zero, accumulate and emit phases
// ----------------------------------------------------------------------------
module mma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          req_type,
  input  logic                out_free,
  output mma_pkg::mma_cmd_t   cmd,
  input  mma_pkg::mma_sts_t   sts
);

  mma_pkg::state_e state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (req_type == mma_pkg::REQ_PROCESS) state_nxt = mma_pkg::ST_ZERO;
          else if (req_type == mma_pkg::REQ_ADD ||
                   req_type == mma_pkg::REQ_REMOVE) state_nxt = mma_pkg::ST_SCAN;
          else state_nxt = mma_pkg::ST_UPDATE;
        end
      end
      mma_pkg::ST_SCAN:   if (sts.idx_last) state_nxt = mma_pkg::ST_UPDATE;
      mma_pkg::ST_UPDATE: state_nxt = mma_pkg::ST_ACK;
      mma_pkg::ST_ACK:    if (out_free) state_nxt = mma_pkg::ST_IDLE;
      mma_pkg::ST_ZERO:   if (sts.idx_last) state_nxt = mma_pkg::ST_MAC;
      mma_pkg::ST_MAC:    state_nxt = mma_pkg::ST_CONV;
      mma_pkg::ST_CONV: begin
        if (sts.mac_skip) state_nxt = sts.idx_last ? mma_pkg::ST_EMIT : mma_pkg::ST_MAC;
        else if (sts.conv_done) state_nxt = mma_pkg::ST_MUL;
      end
      mma_pkg::ST_MUL:    state_nxt = mma_pkg::ST_ADD;
      mma_pkg::ST_ADD:    state_nxt = sts.idx_last ? mma_pkg::ST_EMIT : mma_pkg::ST_MAC;
      mma_pkg::ST_EMIT: begin
        if (out_free && sts.emit_last) state_nxt = mma_pkg::ST_IDLE;
      end
      default:            state_nxt = mma_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.scan_clr = 1'b1;
        cmd.idx_clr  = 1'b1;
      end
      mma_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.idx_inc   = 1'b1;
      end
      mma_pkg::ST_UPDATE: cmd.do_update = 1'b1;
      mma_pkg::ST_ACK:    cmd.ack_load = out_free;
      mma_pkg::ST_ZERO: begin
        cmd.zero_acc = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_last) cmd.idx_clr = 1'b1;
      end
      mma_pkg::ST_MAC:    cmd.mac_read = 1'b1;
      mma_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.mac_skip) begin
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) cmd.idx_clr = 1'b1;
        end
      end
      mma_pkg::ST_MUL:    cmd.mul = 1'b1;
      mma_pkg::ST_ADD: begin
        cmd.add     = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) cmd.idx_clr = 1'b1;
      end
      mma_pkg::ST_EMIT: begin
        cmd.emit_load = out_free;
        cmd.idx_inc   = out_free;
      end
      default: ;
    endcase
  end

  `include "modulation_matrix_accumulator_assert.svh"

  `MMA_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> (state_r == mma_pkg::ST_IDLE), "ready outside idle")
  `MMA_ASSERT(a_ack_one, clk, rst_n, (state_r == mma_pkg::ST_UPDATE) |=> (state_r == mma_pkg::ST_ACK), "update not followed by ack")
  `MMA_ASSERT(a_emit_exit, clk, rst_n, (state_r == mma_pkg::ST_EMIT && out_free && sts.emit_last) |=> (state_r == mma_pkg::ST_IDLE), "emit did not finish")

endmodule

### src/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// source store, connection table, converter, multiplier and accumulators
// ----------------------------------------------------------------------------
module mma_datapath #(
  parameter int NUM_DEST = 16,
  parameter int MAX_CONN = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  mma_pkg::in_item_t   in_item,
  input  logic [3:0]          cutoff_idx,
  input  logic [3:0]          reso_idx,
  input  mma_pkg::mma_cmd_t   cmd,
  output mma_pkg::mma_sts_t   sts,
  output logic                out_load,
  output mma_pkg::out_item_t  out_item
);

  localparam int CW   = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam int DW   = $clog2(NUM_DEST);
  localparam int EMIT = (NUM_DEST < 16) ? NUM_DEST : 16;
  localparam int WW   = ((MAX_CONN > NUM_DEST) ? $clog2(MAX_CONN+1) : $clog2(NUM_DEST+1));

  // latched request
  mma_pkg::in_item_t req_r;
  always_ff @(posedge clk) if (in_fire) req_r <= in_item;

  logic src_ok, dst_ok;
  assign src_ok = req_r.source_sel < 4'(mma_pkg::NUM_SRC);
  assign dst_ok = 32'(req_r.dest_sel) < NUM_DEST;

  // walk index
  logic [WW-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
  end

  // storage
  logic signed [15:0]        src_r [mma_pkg::NUM_SRC];
  logic [MAX_CONN-1:0]       cval_r;
  logic [3:0]                csrc_r [MAX_CONN];
  logic [3:0]                cdst_r [MAX_CONN];
  logic signed [15:0]        camt_r [MAX_CONN];
  logic signed [39:0]        acc_r  [NUM_DEST];

  logic [CW-1:0] ci;
  assign ci = CW'(idx_r);

  // scan for hit and free slot
  logic          hit_v_r, free_v_r;
  logic [CW-1:0] hit_r, free_r;
  logic          match;
  assign match = cval_r[ci] && csrc_r[ci] == req_r.source_sel &&
                 cdst_r[ci] == req_r.dest_sel;
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      hit_v_r  <= 1'b0;
      free_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (match && !hit_v_r) begin
        hit_v_r <= 1'b1;
        hit_r   <= ci;
      end
      if (!cval_r[ci] && !free_v_r) begin
        free_v_r <= 1'b1;
        free_r   <= ci;
      end
    end
  end

  // remove marks all matches during scan
  logic rm_now;
  assign rm_now = cmd.scan_step && match && req_r.req_type == mma_pkg::REQ_REMOVE &&
                  src_ok && dst_ok;

  logic full_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cval_r <= '0;
      full_r <= 1'b0;
    end else begin
      if (rm_now) cval_r[ci] <= 1'b0;
      if (cmd.do_update) begin
        full_r <= 1'b0;
        if (req_r.req_type == mma_pkg::REQ_CLEAR) cval_r <= '0;
        if (req_r.req_type == mma_pkg::REQ_ADD && src_ok && dst_ok) begin
          if (hit_v_r) camt_r[hit_r] <= req_r.amount;
          else if (free_v_r) begin
            cval_r[free_r] <= 1'b1;
            csrc_r[free_r] <= req_r.source_sel;
            cdst_r[free_r] <= req_r.dest_sel;
            camt_r[free_r] <= req_r.amount;
          end else full_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mma_pkg::NUM_SRC; i++) src_r[i] <= '0;
    end else if (cmd.do_update && req_r.req_type == mma_pkg::REQ_SET_SRC && src_ok) begin
      src_r[req_r.source_sel] <= req_r.source_value;
    end
  end

  // connection read
  logic [3:0]         m_src_r;
  logic [3:0]         m_dst_r;
  logic signed [15:0] m_amt_r;
  logic               m_use_r;
  always_ff @(posedge clk) begin
    if (cmd.mac_read) begin
      m_src_r <= csrc_r[ci];
      m_dst_r <= cdst_r[ci];
      m_amt_r <= camt_r[ci];
      m_use_r <= cval_r[ci] && csrc_r[ci] < 4'(mma_pkg::NUM_SRC) &&
                 32'(cdst_r[ci]) < NUM_DEST;
    end
  end

  // source conversion: clamp the raw value, then round by reciprocal multiply
  // velocity and cc: floor((|k|*16384 + 63) / 127) with k = 2v - 127
  // note: floor((|k|*16384 + 30) / 60) with k = n - 60
  // raw values beyond -128..255 saturate either way, so the clamp is exact
  localparam logic [23:0] RECIP_127 = 24'd8454661;  // ceil(2^30 / 127)
  localparam logic [23:0] RECIP_60  = 24'd8947849;  // ceil(2^29 / 60)

  logic               cv_done_r, cv_neg_r, cv_note_r;
  logic [1:0]         cv_cnt_r;
  logic [22:0]        cv_n_r;
  logic [23:0]        cv_m_r;
  logic [46:0]        cv_p_r;
  logic signed [15:0] q14_r;
  logic signed [15:0] raw;
  logic signed [9:0]  raw_c;
  logic signed [10:0] k;
  logic [8:0]         k_mag;
  logic               is_div, is_note;
  logic [17:0]        q;

  assign raw     = src_r[m_src_r < 4'(mma_pkg::NUM_SRC) ? m_src_r : 4'd0];
  assign is_note = m_src_r == mma_pkg::SRC_NOTE;
  assign is_div  = m_src_r inside {mma_pkg::SRC_VELOCITY, mma_pkg::SRC_CC, mma_pkg::SRC_NOTE};

  always_comb begin
    if (raw < -16'sd128) raw_c = -10'sd128;
    else if (raw > 16'sd255) raw_c = 10'sd255;
    else raw_c = 10'(raw);
  end

  assign k     = is_note ? (11'(raw_c) - 11'sd60) : ($signed({raw_c, 1'b0}) - 11'sd127);
  assign k_mag = k[10] ? 9'(-k) : 9'(k);
  assign q     = cv_note_r ? cv_p_r[46:29] : {1'b0, cv_p_r[46:30]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_done_r <= 1'b0;
      cv_cnt_r  <= '0;
    end else if (cmd.mac_read) begin
      cv_done_r <= 1'b0;
      cv_cnt_r  <= '0;
    end else if (cmd.conv_step && m_use_r && !cv_done_r) begin
      case (cv_cnt_r)
        2'd0: begin
          if (is_div) begin
            cv_neg_r  <= k[10];
            cv_note_r <= is_note;
            cv_n_r    <= {k_mag, 14'd0} + (is_note ? 23'd30 : 23'd63);
            cv_m_r    <= is_note ? RECIP_60 : RECIP_127;
            cv_cnt_r  <= 2'd1;
          end else begin
            q14_r     <= raw;
            cv_done_r <= 1'b1;
          end
        end
        2'd1: begin
          cv_p_r   <= 47'(cv_n_r) * 47'(cv_m_r);
          cv_cnt_r <= 2'd2;
        end
        default: begin
          if (cv_neg_r) q14_r <= (q > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, q}));
          else          q14_r <= (q > 18'd32767) ? 16'sd32767 : 16'(q);
          cv_done_r <= 1'b1;
        end
      endcase
    end
  end

  // multiply and accumulate
  logic signed [mma_pkg::PROD_W-1:0] prod_r;
  always_ff @(posedge clk) if (cmd.mul) prod_r <= q14_r * m_amt_r;

  logic [DW-1:0] zi, ei;
  assign zi = DW'(idx_r);
  assign ei = DW'(idx_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DEST; i++) acc_r[i] <= '0;
    end else if (cmd.zero_acc) acc_r[zi] <= '0;
    else if (cmd.add) acc_r[DW'(m_dst_r)] <= acc_r[DW'(m_dst_r)] + 40'(prod_r);
  end

  // output formation
  logic signed [39:0] ev;
  logic               clamp;
  assign clamp = (4'(ei) == cutoff_idx && 32'(cutoff_idx) < NUM_DEST) ||
                 (4'(ei) == reso_idx && 32'(reso_idx) < NUM_DEST);
  assign ev = (clamp && acc_r[ei][39]) ? 40'sd0 : acc_r[ei];

  always_comb begin
    out_load = cmd.emit_load || cmd.ack_load;
    out_item = '0;
    if (cmd.emit_load) begin
      out_item.dest_index = 4'(ei);
      out_item.dest_value = ev;
      out_item.last       = 32'(idx_r) == EMIT - 1;
    end else begin
      out_item.status = full_r;
      out_item.last   = 1'b1;
    end
  end

  assign sts.idx_last  = cmd.scan_step ? (32'(idx_r) == MAX_CONN - 1) :
                         cmd.zero_acc  ? (32'(idx_r) == NUM_DEST - 1) :
                                         (32'(idx_r) == MAX_CONN - 1);
  assign sts.conv_done = cv_done_r;
  assign sts.mac_skip  = !m_use_r;
  assign sts.emit_last = 32'(idx_r) == EMIT - 1;

  `include "modulation_matrix_accumulator_assert.svh"

  `MMA_ASSERT(a_zero_in_range, clk, rst_n, cmd.zero_acc |-> (32'(idx_r) < NUM_DEST), "zero index out of range")
  `MMA_ASSERT(a_add_dest_ok, clk, rst_n, cmd.add |-> (32'(m_dst_r) < NUM_DEST), "accumulate to bad dest")
  `MMA_ASSERT(a_mul_ready, clk, rst_n, cmd.mul |-> cv_done_r, "multiply before conversion")

endmodule

### src/modulation_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// modulation_matrix_accumulator
// synth modulation matrix: sources, connection table, Q12.28 destination sums
// ----------------------------------------------------------------------------
//  channel | ports            | direction | payload
//  input   | in_valid/ready   | in        | mma_pkg::in_item_t
//  result  | out_valid/ready  | out       | mma_pkg::out_item_t
//  config  | cfg_p*           | in/out    | two 4-bit clamp indexes
//
// one item at a time; set, clear and unknown requests pass update and ack,
// add and remove first scan the whole connection table
// process: zero every sum, then per connection read it and skip it if unused,
// else convert the source (reciprocal multiply for velocity/note/cc), multiply
// and add; then one emitted sum per cycle while the output is free
// an output register holds each result; a stalled result stalls the walk
// reset: synchronous, clears table valid bits, sources and sums at once
module modulation_matrix_accumulator #(
  parameter int NUM_DEST = 16,
  parameter int MAX_CONN = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mma_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mma_pkg::out_item_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam logic [2:0] ADDR_CUTOFF = 3'd0;
  localparam logic [2:0] ADDR_RESO   = 3'd4;

  // config registers
  logic [3:0] cutoff_r, reso_r;
  logic       wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 4'd0;
      reso_r   <= 4'd1;
    end else if (wr) begin
      if (cfg_paddr == ADDR_CUTOFF) cutoff_r <= cfg_pwdata[3:0];
      else if (cfg_paddr == ADDR_RESO) reso_r <= cfg_pwdata[3:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_CUTOFF) cfg_prdata[3:0] = cutoff_r;
    else if (cfg_paddr == ADDR_RESO) cfg_prdata[3:0] = reso_r;
  end

  mma_pkg::mma_cmd_t  cmd;
  mma_pkg::mma_sts_t  sts;
  mma_pkg::out_item_t dp_item;
  logic               dp_load, out_free;

  assign out_free = !out_valid || out_ready;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (in_data.req_type),
    .out_free (out_free),
    .cmd      (cmd),
    .sts      (sts)
  );

  mma_datapath #(.NUM_DEST(NUM_DEST), .MAX_CONN(MAX_CONN)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_valid && in_ready),
    .in_item    (in_data),
    .cutoff_idx (cutoff_r),
    .reso_idx   (reso_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_load   (dp_load),
    .out_item   (dp_item)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (dp_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) if (dp_load) out_data <= dp_item;

endmodule
